[sv/bpd_pkg.sv]
package bpd_pkg;

  localparam int MAX_DIM_DEF   = 2048;
  localparam int PAL_DEPTH_DEF = 256;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 14;
  localparam int RGB_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int BYTE_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd4;

  localparam logic OP_PAL = 1'b0;
  localparam logic OP_PIX = 1'b1;

  typedef enum logic [1:0] {
    MODE_4BPP  = 2'd0,
    MODE_8BPP  = 2'd1,
    MODE_24BPP = 2'd2,
    MODE_OFF   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SRC_RAM    = 2'd0,
    SRC_DIRECT = 2'd1,
    SRC_ZERO   = 2'd2
  } src_t;

  localparam mode_t            RST_MODE   = MODE_8BPP;
  localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd1;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd1;
  localparam logic [CFG_W-1:0] RST_CX     = 12'd683;
  localparam logic [CFG_W-1:0] RST_CY     = 12'd384;

  typedef struct packed {
    logic [1:0]         vld;
    src_t               src0;
    logic [RGB_W-1:0]   rgb;
    logic [COORD_W-1:0] sx0;
    logic [COORD_W-1:0] sx1;
    logic [COORD_W-1:0] sy;
    logic [1:0]         fe;
  } pix_req_t;

endpackage

[sv/bpd_ram.sv]
module bpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/bpd_walk.sv]
module bpd_walk #(
  parameter int MAX_DIM       = bpd_pkg::MAX_DIM_DEF,
  parameter int PALETTE_DEPTH = bpd_pkg::PAL_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             load,
  input  logic                             op,
  input  logic [bpd_pkg::BYTE_W-1:0]       data_byte,
  input  logic [bpd_pkg::BYTE_W-1:0]       palette_index,
  input  logic [bpd_pkg::RGB_W-1:0]        palette_rgb,
  output logic                             pal_we,
  output logic [$clog2(PALETTE_DEPTH)-1:0] pal_waddr,
  output logic [bpd_pkg::RGB_W-1:0]        pal_wdata,
  output logic [$clog2(PALETTE_DEPTH)-1:0] addr_a,
  output logic [$clog2(PALETTE_DEPTH)-1:0] addr_b,
  output bpd_pkg::pix_req_t                req
);

  import bpd_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int RB_W   = $clog2(3 * MAX_DIM + 4);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  mode_t            mode_r, mode_nxt;
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [CFG_W-1:0] cx_r, cx_nxt;
  logic [CFG_W-1:0] cy_r, cy_nxt;

  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [RB_W-1:0]   rbc_r, rbc_nxt;
  logic [15:0]       partial_r, partial_nxt;
  phase_t            phase_r, phase_nxt;
  logic              done_r, done_nxt;

  logic [DIM_W-1:0]  w, h, col1, row1;
  logic [RB_W-1:0]   db, stride, rbc1;
  logic              in_data, row_end, col_lt, col1_lt, fe0, fe1, run, idx_ok;
  logic              last_row, cfg_hit;

  always_comb begin
    if (width_r == '0) begin
      w = DIM_W'(1);
    end else if (32'(width_r) > MAX_DIM) begin
      w = DIM_W'(MAX_DIM);
    end else begin
      w = DIM_W'(width_r);
    end
    if (height_r == '0) begin
      h = DIM_W'(1);
    end else if (32'(height_r) > MAX_DIM) begin
      h = DIM_W'(MAX_DIM);
    end else begin
      h = DIM_W'(height_r);
    end
    case (mode_r)
      MODE_4BPP: begin
        db = (RB_W'(w) + RB_W'(1)) >> 1;
      end
      MODE_8BPP: begin
        db = RB_W'(w);
      end
      default: begin
        db = (RB_W'(w) << 1) + RB_W'(w);
      end
    endcase
    stride   = (db + RB_W'(3)) & ~RB_W'(3);
    rbc1     = rbc_r + RB_W'(1);
    in_data  = rbc_r < db;
    row_end  = rbc1 >= stride;
    col1     = col_r + DIM_W'(1);
    row1     = row_r + DIM_W'(1);
    col_lt   = col_r < w;
    col1_lt  = col1 < w;
    last_row = row_r == (h - DIM_W'(1));
    fe0      = last_row && (col_r == (w - DIM_W'(1)));
    fe1      = last_row && (col1 == (w - DIM_W'(1)));
    run      = (op == OP_PIX) && !done_r && (mode_r != MODE_OFF);
    idx_ok   = 32'(data_byte) < PALETTE_DEPTH;
  end

  always_comb begin
    req      = '0;
    req.src0 = SRC_RAM;
    req.rgb  = {data_byte, partial_r[15:8], partial_r[7:0]};
    req.sx0  = COORD_W'(cx_r) - COORD_W'(w >> 1) + COORD_W'(col_r);
    req.sx1  = req.sx0 + COORD_W'(1);
    req.sy   = COORD_W'(cy_r) + COORD_W'(h >> 1) - COORD_W'(row_r);
    req.fe   = {fe1, fe0};
    addr_a   = PAL_AW'(data_byte);
    addr_b   = PAL_AW'(data_byte[3:0]);
    case (mode_r)
      MODE_4BPP: begin
        addr_a     = PAL_AW'(data_byte[7:4]);
        req.vld[0] = in_data && col_lt;
        req.vld[1] = in_data && col_lt && col1_lt && !fe0;
      end
      MODE_8BPP: begin
        req.vld[0] = in_data && col_lt;
        req.src0   = idx_ok ? SRC_RAM : SRC_ZERO;
      end
      MODE_24BPP: begin
        req.vld[0] = in_data && (phase_r == PH_RED) && col_lt;
        req.src0   = SRC_DIRECT;
      end
      default: begin
        req.vld = '0;
      end
    endcase
    if (!run) begin
      req.vld = '0;
    end
  end

  assign pal_we    = load && (op == OP_PAL) && (32'(palette_index) < PALETTE_DEPTH);
  assign pal_waddr = PAL_AW'(palette_index);
  assign pal_wdata = palette_rgb;

  always_comb begin
    mode_nxt    = mode_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    rbc_nxt     = rbc_r;
    partial_nxt = partial_r;
    phase_nxt   = phase_r;
    done_nxt    = done_r;
    cfg_hit     = 1'b0;
    if (cfg_we) begin
      cfg_hit = 1'b1;
      case (cfg_index)
        REG_MODE:   mode_nxt   = mode_t'(cfg_data[1:0]);
        REG_WIDTH:  width_nxt  = cfg_data;
        REG_HEIGHT: height_nxt = cfg_data;
        REG_CX:     cx_nxt     = cfg_data;
        REG_CY:     cy_nxt     = cfg_data;
        default:    cfg_hit    = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      col_nxt     = '0;
      row_nxt     = '0;
      rbc_nxt     = '0;
      partial_nxt = '0;
      phase_nxt   = PH_BLUE;
      done_nxt    = 1'b0;
    end else if (load && run) begin
      col_nxt = col_r + DIM_W'(req.vld[0]) + DIM_W'(req.vld[1]);
      if ((req.vld[0] && fe0) || (req.vld[1] && fe1)) begin
        done_nxt = 1'b1;
      end
      if (mode_r == MODE_24BPP && in_data) begin
        case (phase_r)
          PH_BLUE: begin
            partial_nxt = {8'd0, data_byte};
            phase_nxt   = PH_GREEN;
          end
          PH_GREEN: begin
            partial_nxt = {data_byte, partial_r[7:0]};
            phase_nxt   = PH_RED;
          end
          default: begin
            phase_nxt = PH_BLUE;
          end
        endcase
      end
      rbc_nxt = rbc1;
      if (row_end) begin
        rbc_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = PH_BLUE;
        row_nxt   = row1;
        if (row1 >= h) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RST_MODE;
      width_r   <= RST_WIDTH;
      height_r  <= RST_HEIGHT;
      cx_r      <= RST_CX;
      cy_r      <= RST_CY;
      col_r     <= '0;
      row_r     <= '0;
      rbc_r     <= '0;
      partial_r <= '0;
      phase_r   <= PH_BLUE;
      done_r    <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      rbc_r     <= rbc_nxt;
      partial_r <= partial_nxt;
      phase_r   <= phase_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

[sv/bpd_emit.sv]
module bpd_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  bpd_pkg::pix_req_t                   req,
  input  logic [bpd_pkg::RGB_W-1:0]           rdata_a,
  input  logic [bpd_pkg::RGB_W-1:0]           rdata_b,
  output logic                                take_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bpd_pkg::CHAN_W-1:0]          out_red,
  output logic [bpd_pkg::CHAN_W-1:0]          out_green,
  output logic [bpd_pkg::CHAN_W-1:0]          out_blue,
  output logic signed [bpd_pkg::COORD_W-1:0]  out_screen_x,
  output logic signed [bpd_pkg::COORD_W-1:0]  out_screen_y,
  output logic                                out_last,
  output logic                                out_frame_end
);

  import bpd_pkg::*;

  pix_req_t           s1_r;
  logic [1:0]         s1_vld_r, s1_vld_nxt;
  logic               out_vld_r, out_ready, move;
  logic [1:0]         moved;
  logic [RGB_W-1:0]   sel_rgb, rgb_r;
  logic [COORD_W-1:0] sel_sx, sx_r, sy_r;
  logic               sel_fe, sel_last, fe_r, last_r;

  assign out_ready = !out_vld_r || !out_stall;
  assign move      = out_ready && (s1_vld_r != 2'b00);
  assign take_ok   = (s1_vld_r == 2'b00) ||
                     (out_ready && (s1_vld_r == 2'b01 || s1_vld_r == 2'b10));

  always_comb begin
    moved = 2'b00;
    if (s1_vld_r[0]) begin
      moved    = 2'b01;
      sel_sx   = s1_r.sx0;
      sel_fe   = s1_r.fe[0];
      sel_last = !s1_vld_r[1];
      case (s1_r.src0)
        SRC_RAM:    sel_rgb = rdata_a;
        SRC_DIRECT: sel_rgb = s1_r.rgb;
        default:    sel_rgb = '0;
      endcase
    end else begin
      moved    = 2'b10;
      sel_sx   = s1_r.sx1;
      sel_fe   = s1_r.fe[1];
      sel_last = 1'b1;
      sel_rgb  = rdata_b;
    end
    if (load) begin
      s1_vld_nxt = req.vld;
    end else if (move) begin
      s1_vld_nxt = s1_vld_r & ~moved;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 2'b00;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (out_ready) begin
        out_vld_r <= move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= req;
    end
    if (move) begin
      rgb_r  <= sel_rgb;
      sx_r   <= sel_sx;
      sy_r   <= s1_r.sy;
      fe_r   <= sel_fe;
      last_r <= sel_last;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_red       = rgb_r[23:16];
  assign out_green     = rgb_r[15:8];
  assign out_blue      = rgb_r[7:0];
  assign out_screen_x  = $signed(sx_r);
  assign out_screen_y  = $signed(sy_r);
  assign out_last      = last_r;
  assign out_frame_end = fe_r;

endmodule

[sv/bmp_palette_pixel_decoder_top.sv]
// BMP raster decoder: palette-load beats (op 0) fill a 24-bit palette, raster beats (op 1)
// give RGB pixels with screen coordinates, rows bottom-up, each row padded to 4 bytes and
// the image centred on (center_x, center_y). A beat is taken every cycle in 8 bpp and 24 bpp
// mode and for palette loads while the output is not stalled; a 4 bpp byte that gives two
// pixels holds the input until its first pixel has moved on, since the single output register
// drains one pixel per cycle when not stalled. An accepted raster byte passes the palette read
// register (two RAM copies give the two nibble lookups in the same cycle), then the output register.
// The palette powers up unwritten; register writes restart the frame but keep the palette.
module bmp_palette_pixel_decoder_top #(
  parameter int MAX_DIM       = bpd_pkg::MAX_DIM_DEF,
  parameter int PALETTE_DEPTH = bpd_pkg::PAL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [bpd_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic [bpd_pkg::BYTE_W-1:0]         in_palette_index,
  input  logic [bpd_pkg::RGB_W-1:0]          in_palette_rgb,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bpd_pkg::CHAN_W-1:0]         out_red,
  output logic [bpd_pkg::CHAN_W-1:0]         out_green,
  output logic [bpd_pkg::CHAN_W-1:0]         out_blue,
  output logic signed [bpd_pkg::COORD_W-1:0] out_screen_x,
  output logic signed [bpd_pkg::COORD_W-1:0] out_screen_y,
  output logic                               out_last,
  output logic                               out_frame_end,
  input  logic                               cfg_we,
  input  logic [bpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpd_pkg::CFG_W-1:0]          cfg_data
);

  import bpd_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  logic              load, take_ok, pal_we;
  logic [PAL_AW-1:0] pal_waddr, addr_a, addr_b;
  logic [RGB_W-1:0]  pal_wdata, rdata_a, rdata_b;
  pix_req_t          req;

  assign in_stall = !take_ok;
  assign load     = in_valid && take_ok;

  bpd_walk #(
    .MAX_DIM       (MAX_DIM),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .load          (load),
    .op            (in_op),
    .data_byte     (in_data_byte),
    .palette_index (in_palette_index),
    .palette_rgb   (in_palette_rgb),
    .pal_we        (pal_we),
    .pal_waddr     (pal_waddr),
    .pal_wdata     (pal_wdata),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .req           (req)
  );

  bpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_a (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (load),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  bpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_b (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (load),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  bpd_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .req           (req),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .take_ok       (take_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_screen_x  (out_screen_x),
    .out_screen_y  (out_screen_y),
    .out_last      (out_last),
    .out_frame_end (out_frame_end)
  );

endmodule
